@@ rtl/wheel_encoder_move_tracker_defines.svh @@
// assertion macros for the tracker rtl
`ifndef WHEEL_ENCODER_MOVE_TRACKER_DEFINES_SVH
`define WHEEL_ENCODER_MOVE_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WEMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WEMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wemt_pkg.sv @@
package wemt_pkg;

  // default encoder count width
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // item kind, carried on in_tuser
  localparam logic ACTION_START  = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  // move modes
  localparam logic [1:0] MODE_FORWARD = 2'd0;
  localparam logic [1:0] MODE_REVERSE = 2'd1;
  localparam logic [1:0] MODE_LEFT    = 2'd2;
  localparam logic [1:0] MODE_RIGHT   = 2'd3;

  typedef logic [1:0] mode_t;

  // wheel direction decode for one mode
  typedef struct packed {
    logic left_plus;
    logic right_plus;
    logic straight;
  } dir_t;

  function automatic dir_t mode_dir(input mode_t mode);
    dir_t d;
    d = '0;
    unique case (mode)
      MODE_FORWARD: d = '{left_plus: 1'b1, right_plus: 1'b1, straight: 1'b1};
      MODE_REVERSE: d = '{left_plus: 1'b0, right_plus: 1'b0, straight: 1'b1};
      MODE_LEFT:    d = '{left_plus: 1'b0, right_plus: 1'b1, straight: 1'b0};
      MODE_RIGHT:   d = '{left_plus: 1'b1, right_plus: 1'b0, straight: 1'b0};
      default:      d = '0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/wheel_encoder_move_tracker.sv @@
// Wheel encoder move tracker. A start item (in_tuser low) latches both raw
// wheel counts, clears the travelled totals and takes the move mode and the
// target count; every sample item (in_tuser high) then adds each wheel's
// wrap-corrected count delta, taken in the direction that wheel should turn
// for the mode, into a total that saturates at all ones. Forward and reverse
// finish when both totals reach the target, turns when either does; the
// finishing sample comes out with out_tlast set and moving clear, and the
// block goes idle, so samples after it are answered with the held totals.
// A start while a move runs abandons it. Every item gives exactly one result
// item. Throughput is one item per clock while the result side does not stall: an
// item is held in the input register, its update is a subtract, a saturating add and a
// compare per wheel, and the result is registered. in_tready drops only when both
// registers hold items and the result side stalls.
`include "wheel_encoder_move_tracker_defines.svh"

module wheel_encoder_move_tracker #(
  parameter int unsigned COUNT_WIDTH = wemt_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned IN_W  = ((2 + 3 * COUNT_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((1 + 2 * COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_tvalid,
  output logic             in_tready,
  // move_mode, target_count, left_count, right_count, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  // action
  input  logic             in_tuser,
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  // moving, left_travelled, right_travelled, zero pad
  output logic [OUT_W-1:0] out_tdata,
  // stop_now
  output logic             out_tlast
);
  import wemt_pkg::*;

  localparam int unsigned CW      = COUNT_WIDTH;
  localparam int unsigned OUT_PAD = OUT_W - (1 + 2 * CW);

  // input register
  logic          s1_valid_r;
  logic          s1_action_r;
  mode_t         s1_mode_r;
  logic [CW-1:0] s1_target_r;
  logic [CW-1:0] s1_left_r;
  logic [CW-1:0] s1_right_r;

  // move state
  logic [CW-1:0] left_prev_r, left_prev_nxt;
  logic [CW-1:0] right_prev_r, right_prev_nxt;
  logic [CW-1:0] left_tot_r, left_tot_nxt;
  logic [CW-1:0] right_tot_r, right_tot_nxt;
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] goal_r, goal_nxt;
  logic          busy_r, busy_nxt;
  logic          stop_nxt;

  // result register
  logic          out_valid_r;
  logic          out_stop_r;
  logic          out_moving_r;
  logic [CW-1:0] out_left_r;
  logic [CW-1:0] out_right_r;

  logic in_load;
  logic out_load;

  // result register frees when empty or taken; input register frees when its item moves on
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload unpack, lowest field first
  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_action_r <= in_tuser;
      s1_mode_r   <= in_tdata[1:0];
      s1_target_r <= in_tdata[2 +: CW];
      s1_left_r   <= in_tdata[2 + CW +: CW];
      s1_right_r  <= in_tdata[2 + 2 * CW +: CW];
    end
  end

  // per-sample update
  dir_t          dir;
  logic [CW-1:0] left_delta;
  logic [CW-1:0] right_delta;
  logic [CW:0]   left_sum;
  logic [CW:0]   right_sum;
  logic [CW-1:0] left_sat;
  logic [CW-1:0] right_sat;
  logic          left_reach;
  logic          right_reach;
  logic          done;

  always_comb begin
    dir = mode_dir(mode_r);
    // modular difference, wrap step counts like any other step
    left_delta  = dir.left_plus  ? (s1_left_r - left_prev_r)   : (left_prev_r - s1_left_r);
    right_delta = dir.right_plus ? (s1_right_r - right_prev_r) : (right_prev_r - s1_right_r);
    left_sum    = {1'b0, left_tot_r} + {1'b0, left_delta};
    right_sum   = {1'b0, right_tot_r} + {1'b0, right_delta};
    left_sat    = left_sum[CW]  ? '1 : left_sum[CW-1:0];
    right_sat   = right_sum[CW] ? '1 : right_sum[CW-1:0];
    left_reach  = left_sat >= goal_r;
    right_reach = right_sat >= goal_r;
    done        = dir.straight ? (left_reach && right_reach) : (left_reach || right_reach);

    left_prev_nxt  = left_prev_r;
    right_prev_nxt = right_prev_r;
    left_tot_nxt   = left_tot_r;
    right_tot_nxt  = right_tot_r;
    mode_nxt       = mode_r;
    goal_nxt       = goal_r;
    busy_nxt       = busy_r;
    stop_nxt       = 1'b0;

    if (s1_action_r == ACTION_START) begin
      left_prev_nxt  = s1_left_r;
      right_prev_nxt = s1_right_r;
      left_tot_nxt   = '0;
      right_tot_nxt  = '0;
      mode_nxt       = s1_mode_r;
      goal_nxt       = s1_target_r;
      busy_nxt       = 1'b1;
    end else if (busy_r) begin
      left_prev_nxt  = s1_left_r;
      right_prev_nxt = s1_right_r;
      left_tot_nxt   = left_sat;
      right_tot_nxt  = right_sat;
      if (done) begin
        stop_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
    // sample while idle leaves everything as it is
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_prev_r  <= '0;
      right_prev_r <= '0;
      left_tot_r   <= '0;
      right_tot_r  <= '0;
      mode_r       <= MODE_FORWARD;
      goal_r       <= '0;
      busy_r       <= 1'b0;
    end else if (out_load) begin
      left_prev_r  <= left_prev_nxt;
      right_prev_r <= right_prev_nxt;
      left_tot_r   <= left_tot_nxt;
      right_tot_r  <= right_tot_nxt;
      mode_r       <= mode_nxt;
      goal_r       <= goal_nxt;
      busy_r       <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stop_r   <= stop_nxt;
      out_moving_r <= busy_nxt;
      out_left_r   <= left_tot_nxt;
      out_right_r  <= right_tot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_stop_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_right_r, out_left_r, out_moving_r};

  // a finishing sample never reports the move as still running
  `WEMT_ASSERT_NOW(a_stop_not_moving, out_valid_r && out_stop_r, !out_moving_r, "stop with moving set")
  // a start always leaves a running move with cleared totals
  `WEMT_ASSERT_NEXT(a_start_clears, out_load && s1_action_r == ACTION_START, busy_r && out_left_r == '0 && out_right_r == '0 && !out_stop_r, "start did not clear the move")
  // the move ends only through a reported stop
  `WEMT_ASSERT_NEXT(a_busy_fall, busy_r && !busy_nxt && out_load, out_stop_r && out_valid_r, "move ended without stop")
  // an empty input register always takes an item
  `WEMT_ASSERT_NOW(a_ready_empty, !s1_valid_r, in_tready, "input stalled while empty")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import wemt_pkg::*;

  localparam int unsigned CW     = COUNT_WIDTH_DEF;
  localparam int unsigned IN_W   = ((2 + 3 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((1 + 2 * CW + 7) / 8) * 8;
  localparam int          LIMIT  = 200000;
  localparam int          HOLD_N = 300;
  localparam int          PHASE_ITEMS = 385;

  // one input item as the block sees it
  typedef struct packed {
    logic          action;
    mode_t         mode;
    logic [CW-1:0] target;
    logic [CW-1:0] lcount;
    logic [CW-1:0] rcount;
  } move_item_t;

  // one result item
  typedef struct packed {
    logic          stop_now;
    logic          moving;
    logic [CW-1:0] ltrav;
    logic [CW-1:0] rtrav;
  } move_status_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  wheel_encoder_move_tracker #(.COUNT_WIDTH(CW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  move_item_t   pending_items[$];
  move_status_t awaited_status[$];
  move_item_t   on_bus;
  int           snd_idle_pct = 0;
  int           rcv_stall_pct = 0;
  int           hold_req_id = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           mismatches = 0;
  int           cycle_cnt = 0;

  // tracker state mirrored in the bench
  logic [CW-1:0] left_prev, right_prev, left_sum, right_sum, goal_cnt;
  mode_t         cur_mode;
  logic          in_move;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // wrap-corrected delta taken in the wheel's expected direction, saturating total
  function automatic logic [CW-1:0] add_travel(input logic [CW-1:0] sum, input logic [CW-1:0] prev,
                                               input logic [CW-1:0] now, input logic plus);
    logic [CW-1:0] delta;
    logic [CW:0]   wide;
    delta = plus ? now - prev : prev - now;
    wide  = {1'b0, sum} + {1'b0, delta};
    return wide[CW] ? {CW{1'b1}} : wide[CW-1:0];
  endfunction

  // advance the mirrored tracker by one item and give its result
  function automatic move_status_t track_move(input move_item_t it);
    move_status_t res;
    logic lplus, rplus, lreach, rreach, done;
    res = '0;
    if (it.action == ACTION_START) begin
      left_prev  = it.lcount;
      right_prev = it.rcount;
      left_sum   = '0;
      right_sum  = '0;
      cur_mode   = it.mode;
      goal_cnt   = it.target;
      in_move    = 1'b1;
    end else if (in_move) begin
      lplus      = (cur_mode == MODE_FORWARD) || (cur_mode == MODE_RIGHT);
      rplus      = (cur_mode == MODE_FORWARD) || (cur_mode == MODE_LEFT);
      left_sum   = add_travel(left_sum, left_prev, it.lcount, lplus);
      right_sum  = add_travel(right_sum, right_prev, it.rcount, rplus);
      left_prev  = it.lcount;
      right_prev = it.rcount;
      lreach     = left_sum >= goal_cnt;
      rreach     = right_sum >= goal_cnt;
      // straight moves need both wheels there, turns only one
      if (cur_mode == MODE_FORWARD || cur_mode == MODE_REVERSE)
        done = lreach && rreach;
      else
        done = lreach || rreach;
      if (done) begin
        res.stop_now = 1'b1;
        in_move      = 1'b0;
      end
    end
    res.moving = in_move;
    res.ltrav  = left_sum;
    res.rtrav  = right_sum;
    return res;
  endfunction

  // driver: predicts on accept, then offers the next pending item or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= 1'b0;
      left_prev  = '0;
      right_prev = '0;
      left_sum   = '0;
      right_sum  = '0;
      goal_cnt   = '0;
      cur_mode   = MODE_FORWARD;
      in_move    = 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        awaited_status.push_back(track_move(on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          on_bus    = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_W - 2 - 3 * CW){1'b0}}, on_bus.rcount, on_bus.lcount,
                        on_bus.target, on_bus.mode};
          in_tuser  <= on_bus.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_seen != hold_req_id) begin
      hold_seen <= hold_req_id;
      hold_left <= HOLD_N;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
  end

  // monitor: every result item against the oldest prediction
  always @(posedge clk) begin : result_check
    move_status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{stop_now: out_tlast, moving: out_tdata[0],
              ltrav: out_tdata[CW:1], rtrav: out_tdata[2*CW:CW+1]};
      if (awaited_status.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: stop %0b moving %0b left %0d right %0d",
                   got.stop_now, got.moving, got.ltrav, got.rtrav);
        mismatches = mismatches + 1;
      end else begin
        want = awaited_status.pop_front();
        if (got.stop_now !== want.stop_now || got.moving !== want.moving ||
            got.ltrav !== want.ltrav || got.rtrav !== want.rtrav) begin
          if (mismatches < 10)
            $display("mismatch: exp stop %0b moving %0b left %0d right %0d, got %0b %0b %0d %0d",
                     want.stop_now, want.moving, want.ltrav, want.rtrav,
                     got.stop_now, got.moving, got.ltrav, got.rtrav);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  task automatic push_item(input logic action, input mode_t mode, input logic [CW-1:0] target,
                           input logic [CW-1:0] lcount, input logic [CW-1:0] rcount);
    move_item_t it;
    it = '{action: action, mode: mode, target: target, lcount: lcount, rcount: rcount};
    pending_items.push_back(it);
  endtask

  // block until every queued item went in and every result came out
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_tvalid || awaited_status.size() != 0)
      @(negedge clk);
  endtask

  // random moves: mostly plausible wheel travel, some jitter, noise and abandoned moves
  task automatic gen_moves(input int n);
    int            made, nsamp, step_max, roll;
    mode_t         mode;
    logic [CW-1:0] target, lc, rc;
    logic          lplus, rplus;
    made = 0;
    while (made < n) begin
      mode = mode_t'($urandom_range(3));
      roll = $urandom_range(99);
      if (roll < 55)
        target = CW'($urandom_range(120));
      else if (roll < 65)
        target = '0;
      else if (roll < 85)
        target = CW'($urandom_range(5000, 121));
      else
        target = CW'($urandom);
      step_max = int'(target) / 8 + 2;
      lc = CW'($urandom);
      rc = CW'($urandom);
      push_item(ACTION_START, mode, target, lc, rc);
      made++;
      lplus = (mode == MODE_FORWARD) || (mode == MODE_RIGHT);
      rplus = (mode == MODE_FORWARD) || (mode == MODE_LEFT);
      nsamp = int'(target) * 2 / step_max + $urandom_range(4);
      if ($urandom_range(19) == 0)
        nsamp = $urandom_range(2);
      repeat (nsamp) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          lc = CW'($urandom);
          rc = CW'($urandom);
        end else if (roll < 13) begin
          // wheel slips back a little
          lc = lplus ? lc - CW'($urandom_range(3)) : lc + CW'($urandom_range(3));
          rc = rplus ? rc + CW'($urandom_range(step_max)) : rc - CW'($urandom_range(step_max));
        end else begin
          lc = lplus ? lc + CW'($urandom_range(step_max)) : lc - CW'($urandom_range(step_max));
          rc = rplus ? rc + CW'($urandom_range(step_max)) : rc - CW'($urandom_range(step_max));
        end
        push_item(ACTION_SAMPLE, mode_t'($urandom), CW'($urandom), lc, rc);
        made++;
      end
    end
  endtask

  initial begin : stimulus
    int snd_pcts[4];
    int rcv_pcts[4];
    snd_pcts = '{0, 68, 0, 37};
    rcv_pcts = '{0, 0, 68, 37};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle sample, zero target, wrap steps, every mode, abandon, saturation
    push_item(ACTION_SAMPLE, MODE_RIGHT, 16'hFFFF, 16'h1234, 16'hABCD);
    push_item(ACTION_START, MODE_FORWARD, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_item(ACTION_SAMPLE, MODE_LEFT, 16'h5555, 16'h0000, 16'h0000);
    push_item(ACTION_START, MODE_FORWARD, 16'd10, 16'hFFFA, 16'hFFFC);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'h0001, 16'h0002);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'h0004, 16'h0006);
    push_item(ACTION_START, MODE_REVERSE, 16'd5, 16'h0002, 16'h0000);
    push_item(ACTION_SAMPLE, MODE_REVERSE, 16'h0000, 16'hFFFE, 16'hFFFD);
    push_item(ACTION_START, MODE_LEFT, 16'd8, 16'h0000, 16'hFFF8);
    push_item(ACTION_SAMPLE, MODE_LEFT, 16'h0000, 16'hFFFF, 16'h0000);
    push_item(ACTION_START, MODE_RIGHT, 16'd3, 16'h8000, 16'h8000);
    push_item(ACTION_SAMPLE, MODE_RIGHT, 16'h0000, 16'h8001, 16'h7FFF);
    push_item(ACTION_SAMPLE, MODE_RIGHT, 16'h0000, 16'h8001, 16'h7FFC);
    push_item(ACTION_START, MODE_FORWARD, 16'hFFFF, 16'h0000, 16'h0000);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'h8000, 16'h7FFF);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'h0000, 16'hFFFF);
    push_item(ACTION_START, MODE_FORWARD, 16'hFFFF, 16'h0000, 16'h0000);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'hFFFF, 16'h0001);
    push_item(ACTION_SAMPLE, MODE_FORWARD, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_item(ACTION_SAMPLE, MODE_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ACTION_START, MODE_REVERSE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ACTION_SAMPLE, MODE_REVERSE, 16'h0000, 16'h0000, 16'hFFFE);
    wait_drained();

    // random phases; the first one also holds the result side off for a long stretch
    for (int p = 0; p < 4; p++) begin
      snd_idle_pct  = snd_pcts[p];
      rcv_stall_pct = rcv_pcts[p];
      if (p == 0)
        hold_req_id = hold_req_id + 1;
      gen_moves(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited_status.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
